// ----- rtl/i2a_pkg.sv -----
// i2a_pkg: shared types and constants for the int32 to decimal ascii converter
// no dependencies

package i2a_pkg;

   localparam int VALUE_WIDTH       = 32;
   localparam int CHAR_WIDTH        = 6;
   localparam int NUM_DIGITS        = 10;
   localparam int BCD_WIDTH         = 4 * NUM_DIGITS;
   localparam int DIGIT_INDEX_WIDTH = 4;
   localparam int SHIFT_COUNT_WIDTH = 5;

   localparam logic [CHAR_WIDTH-1:0]        ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0]        ASCII_MINUS = 6'd45;
   localparam logic [SHIFT_COUNT_WIDTH-1:0] LAST_SHIFT  = 5'd31;

   // classified number between front and back
   typedef struct packed {
      logic                   negative;
      logic [VALUE_WIDTH-1:0] magnitude;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_LEAD,
      ST_SIGN,
      ST_EMIT
   } back_state_type;

endpackage

// ----- rtl/i2a_if.sv -----
// i2a_req_if and i2a_rsp_if: valid/ready channels of the converter
// depends on i2a_pkg

interface i2a_req_if;
   import i2a_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface i2a_rsp_if;
   import i2a_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] character;
   logic                  last_char;

   modport source (output valid, output character, output last_char, input ready);
   modport sink   (input valid, input character, input last_char, output ready);
endinterface

// ----- rtl/i2a_front.sv -----
// i2a_front: takes a number transfer, splits sign and magnitude, holds it for the queue
// depends on i2a_pkg, i2a_req_if

module i2a_front (
   input  logic              clock,
   input  logic              reset,
   i2a_req_if.sink           req_chan,
   output logic              push_valid,
   input  logic              push_ready,
   output i2a_pkg::item_type push_item
);
   import i2a_pkg::*;

   logic                   hold_valid_ff;
   logic                   hold_valid_in;
   item_type               hold_item_ff;
   item_type               hold_item_in;
   logic [VALUE_WIDTH-1:0] raw;
   logic                   take;

   assign req_chan.ready = !hold_valid_ff || push_ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign raw            = req_chan.value;

   always_comb begin
      hold_item_in.negative  = raw[VALUE_WIDTH-1];
      // two's complement magnitude, most negative value wraps to 2^31 unsigned
      hold_item_in.magnitude = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
      if (take) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hold_item_ff <= hold_item_in;
      end
   end

   assign push_valid = hold_valid_ff;
   assign push_item  = hold_item_ff;

endmodule

// ----- rtl/i2a_queue.sv -----
// i2a_queue: two-entry queue of classified numbers between front and back
// depends on i2a_pkg

module i2a_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  i2a_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop,
   output i2a_pkg::item_type pop_item
);
   import i2a_pkg::*;

   item_type   entries_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_item   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue push lost");
`endif

endmodule

// ----- rtl/i2a_back.sv -----
// i2a_back: shift-add-3 binary to bcd conversion and character emission
// depends on i2a_pkg, i2a_rsp_if

module i2a_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop,
   input  i2a_pkg::item_type pop_item,
   i2a_rsp_if.source         rsp_chan
);
   import i2a_pkg::*;

   back_state_type               state_ff;
   back_state_type               state_in;
   logic [VALUE_WIDTH-1:0]       bin_ff;
   logic [VALUE_WIDTH-1:0]       bin_in;
   logic [BCD_WIDTH-1:0]         bcd_ff;
   logic [BCD_WIDTH-1:0]         bcd_in;
   logic [BCD_WIDTH-1:0]         bcd_adj;
   logic                         neg_ff;
   logic                         neg_in;
   logic [SHIFT_COUNT_WIDTH-1:0] cnt_ff;
   logic [SHIFT_COUNT_WIDTH-1:0] cnt_in;
   logic [DIGIT_INDEX_WIDTH-1:0] idx_ff;
   logic [DIGIT_INDEX_WIDTH-1:0] idx_in;
   logic [DIGIT_INDEX_WIDTH-1:0] top_idx;
   logic [3:0]                   cur_digit;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic [CHAR_WIDTH-1:0]        out_char_ff;
   logic [CHAR_WIDTH-1:0]        out_char_in;
   logic                         out_last_ff;
   logic                         out_last_in;
   logic                         can_load;
   logic                         load;

   assign can_load  = !out_valid_ff || rsp_chan.ready;
   assign cur_digit = bcd_ff[idx_ff*4 +: 4];

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         bcd_adj[d*4 +: 4] = (bcd_ff[d*4 +: 4] >= 4'd5) ?
                             (bcd_ff[d*4 +: 4] + 4'd3) : bcd_ff[d*4 +: 4];
      end
   end

   // highest nonzero digit, zero maps to the ones digit
   always_comb begin
      top_idx = '0;
      for (int d = 1; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) begin
            top_idx = DIGIT_INDEX_WIDTH'(d);
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      bin_in      = bin_ff;
      bcd_in      = bcd_ff;
      neg_in      = neg_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      out_char_in = out_char_ff;
      out_last_in = out_last_ff;
      pop         = 1'b0;
      load        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop      = 1'b1;
               bin_in   = pop_item.magnitude;
               neg_in   = pop_item.negative;
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            bcd_in = {bcd_adj[BCD_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
            bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_SHIFT) begin
               state_in = ST_LEAD;
            end
         end
         ST_LEAD: begin
            idx_in   = top_idx;
            state_in = neg_ff ? ST_SIGN : ST_EMIT;
         end
         ST_SIGN: begin
            if (can_load) begin
               load        = 1'b1;
               out_char_in = ASCII_MINUS;
               out_last_in = 1'b0;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (can_load) begin
               load        = 1'b1;
               out_char_in = ASCII_ZERO + {2'b00, cur_digit};
               out_last_in = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.character = out_char_ff;
   assign rsp_chan.last_char = out_last_ff;

`ifndef NO_ASSERTIONS
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (cur_digit <= 4'd9))
      else $error("bcd digit out of range");
   a_no_lead_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && $past(state_ff) == ST_LEAD) |->
      (idx_ff == '0 || cur_digit != 4'd0))
      else $error("leading zero would be emitted");
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (load && out_last_in) |=> (state_ff == ST_IDLE))
      else $error("run did not end after last character");
`endif

endmodule

// ----- rtl/int32_to_decimal_ascii.sv -----
// a number passes the front hold register, the queue and the 32-step shift-add-3 conversion
// loop in i2a_back, then its text of 1..11 characters comes out, most significant digit first
// a two-entry queue lets the next numbers be taken while one is converted
// reset: synchronous, active high, empties front, queue and back; nothing kept between numbers
// depends on i2a_pkg, i2a_if, i2a_front, i2a_queue, i2a_back

module int32_to_decimal_ascii (
   input  logic      clock,
   input  logic      reset,
   i2a_req_if.sink   req_chan,
   i2a_rsp_if.source rsp_chan
);
   import i2a_pkg::*;

   // front to queue: classified sign and magnitude
   logic     push_valid;
   logic     push_ready;
   item_type push_item;

   // queue to back
   logic     pop_valid;
   logic     pop;
   item_type pop_item;

   // front stage: one number transfer per cycle while the hold register drains
   i2a_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // decoupling queue so the front keeps taking numbers during conversion
   i2a_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   // back end: bcd conversion, sign, digits most significant first,
   // output register so the last character of a number can wait while the next number is converted
   i2a_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_item  (pop_item),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- dv/i2a_check_pkg.sv -----
// i2a_check_pkg: expected character text and its comparison for the converter bench
// depends on i2a_pkg

package i2a_check_pkg;
   import i2a_pkg::*;

   localparam int unsigned RADIX = 10;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last_char;
   } text_char_type;

   class decimal_text_check;
      text_char_type expected_chars[$];
      int            errors;

      function new();
         errors = 0;
      endfunction

      // work out the decimal text of one accepted number, most significant first
      function void note_number(logic [VALUE_WIDTH-1:0] value);
         logic                   negative;
         logic [VALUE_WIDTH-1:0] magnitude;
         logic [3:0]             digits[NUM_DIGITS];
         int                     count;
         text_char_type          next_char;
         negative  = value[VALUE_WIDTH-1];
         // most negative value wraps to 2^31, still exact in 32 unsigned bits
         magnitude = negative ? (~value + 1'b1) : value;
         count     = 0;
         do begin
            digits[count] = 4'(magnitude % RADIX);
            magnitude     = magnitude / RADIX;
            count++;
         end while (magnitude != 0 && count < NUM_DIGITS);
         if (negative) begin
            next_char.character = ASCII_MINUS;
            next_char.last_char = 1'b0;
            expected_chars.push_back(next_char);
         end
         for (int i = count - 1; i >= 0; i--) begin
            next_char.character = ASCII_ZERO + CHAR_WIDTH'(digits[i]);
            next_char.last_char = (i == 0);
            expected_chars.push_back(next_char);
         end
      endfunction

      function void check_char(realtime stamp, logic [CHAR_WIDTH-1:0] character,
                               logic last_char);
         text_char_type want;
         if (expected_chars.size() == 0) begin
            $display("%0t ns: character %0d last %0b with nothing expected",
                     stamp, character, last_char);
            errors++;
         end else begin
            want = expected_chars.pop_front();
            if (character !== want.character) begin
               $display("%0t ns: character expected %0d actual %0d",
                        stamp, want.character, character);
               errors++;
            end
            if (last_char !== want.last_char) begin
               $display("%0t ns: last_char expected %0b actual %0b",
                        stamp, want.last_char, last_char);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

endpackage

// ----- dv/tb.sv -----
// tb: drives numbers into int32_to_decimal_ascii and checks every character that comes out
// depends on i2a_pkg, i2a_if, i2a_check_pkg and the converter rtl

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2a_pkg::*;
   import i2a_check_pkg::*;

   localparam int  MAX_WAIT      = 18;
   localparam int  HOLD_CYCLES   = 400;     // long receiver hold-off, fills the queue
   localparam int  SETTLE_CYCLES = 60;      // extra wait after the last expected character has come out
   localparam int  RANDOM_ITEMS  = 296;
   localparam real TIMEOUT_NS    = 5.0e6;   // several times the slowest legal run

   logic clock;
   logic reset;

   i2a_req_if req_chan ();
   i2a_rsp_if rsp_chan ();

   int32_to_decimal_ascii dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   decimal_text_check expected_text = new();

   // idling modes, flipped now and then so there are stretches with no gaps at all
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   // set by the stimulus, picked up by the receiver for one long hold-off
   bit hold_pending = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int draw_wait(bit quiet);
      return quiet ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // random number with a spread of text lengths and a share of near-boundary values
   function automatic logic [VALUE_WIDTH-1:0] pick_number();
      logic [VALUE_WIDTH-1:0] value;
      int unsigned            power;
      value = '0;
      power = 1;
      case ($urandom_range(0, 5))
         0: begin
            value = $urandom;
         end
         1, 2: begin
            // shift right to get every digit count about equally often
            value = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1)) value = -value;
         end
         3: begin
            // just around a power of ten, where the digit count changes
            repeat ($urandom_range(0, 9)) power = power * 10;
            value = power + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) value = -value;
         end
         4: begin
            value = $urandom_range(0, 20);
            if ($urandom_range(0, 1)) value = -value;
         end
         default: begin
            case ($urandom_range(0, 3))
               0:       value = 32'h8000_0000;
               1:       value = 32'h7fff_ffff;
               2:       value = 32'h8000_0001;
               default: value = '0;
            endcase
         end
      endcase
      return value;
   endfunction

   // offer one number after a gap, return once it has been transferred
   task automatic send_number(input logic [VALUE_WIDTH-1:0] value, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.value <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_text.note_number(value);
   endtask

   // sender stops offering and waits until every expected character has come out
   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_text.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver: random stall before each character, one long hold-off on request
   initial begin : rsp_side
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall = HOLD_CYCLES;
         end else begin
            stall = draw_wait(rsp_quiet);
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         expected_text.check_char($realtime, rsp_chan.character, rsp_chan.last_char);
         if ($urandom_range(0, 49) == 0) rsp_quiet = !rsp_quiet;
      end
   end

   initial begin : stimulus
      // extremes, single digits, digit-count boundaries, both bit patterns
      logic [VALUE_WIDTH-1:0] corner_values[22];
      // all inputs known from time zero
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.value = '0;
      corner_values = '{
         32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
         32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
         32'd999999999, 32'd1999999999, -32'sd1000000000, 32'd12345,
         -32'sd9, 32'h5555_5555, 32'haaaa_aaaa, 32'd1234567890,
         -32'sd987654321, 32'd4294967286
      };
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed part with normal idling
      foreach (corner_values[i]) send_number(corner_values[i], draw_wait(req_quiet));
      drain_results();

      // receiver holds off for a long time while numbers keep coming back to back
      hold_pending = 1'b1;
      repeat (12) send_number(pick_number(), 0);
      drain_results();

      // random part, with one full pause halfway
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 39) == 0) req_quiet = !req_quiet;
         if (i == RANDOM_ITEMS / 2) drain_results();
         send_number(pick_number(), draw_wait(req_quiet));
      end
      drain_results();

      if (expected_text.errors == 0 && expected_text.pending() == 0) begin
         $display("[int32_to_decimal_ascii] OK");
      end else begin
         $display("[int32_to_decimal_ascii] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("[int32_to_decimal_ascii] ERROR");
      $finish;
   end

endmodule
